FILE: rtl/hhr_pkg.sv
// Shared types, constants and byte-matching functions for the HTTP header redactor.
package hhr_pkg;

   localparam int NAME_COUNT  = 5;
   localparam int NAME_MAX    = 14;
   localparam int MARK_LEN    = 12;
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_COLON = 8'h3A;
   localparam logic [7:0] BYTE_UP_A  = 8'h41;
   localparam logic [7:0] BYTE_UP_Z  = 8'h5A;
   localparam logic [7:0] CASE_GAP   = 8'h20;

   localparam logic [NAME_COUNT-1:0] MASK_ALL = '1;
   localparam logic [3:0] LEN_MAX = 4'hF;

   localparam logic [NAME_MAX*8-1:0] SECRET_TEXT [NAME_COUNT] = '{
      "authorization", "cookie", "x-auth-token", "x-api-key", "x-access-token"
   };
   localparam logic [3:0] SECRET_LENS [NAME_COUNT] = '{4'd13, 4'd6, 4'd12, 4'd9, 4'd14};
   localparam logic [MARK_LEN*8-1:0] MARK_TEXT = ": [REDACTED]";

   typedef enum logic [2:0] {
      MODE_REQ,
      MODE_NAME,
      MODE_VALUE,
      MODE_DROP,
      MODE_BODY
   } mode_type;

   typedef enum logic [1:0] {
      MAIN_NONE,
      MAIN_BYTE,
      MAIN_MARK
   } main_kind_type;

   typedef struct packed {
      logic          lead_cr;
      main_kind_type main_kind;
      logic [7:0]    main_byte;
      logic          tail_lf;
      logic          final_beat;
   } cmd_type;

   typedef struct packed {
      logic [NAME_COUNT-1:0] mask;
      logic [3:0]            len;
   } name_state_type;

   function automatic logic [7:0] secret_char(input int idx, input logic [3:0] pos);
      logic [7:0] result;
      result = 8'h00;
      if (pos < SECRET_LENS[idx]) begin
         result = SECRET_TEXT[idx][(int'(SECRET_LENS[idx]) - 1 - int'(pos)) * 8 +: 8];
      end
      return result;
   endfunction

   function automatic logic [7:0] mark_char(input logic [3:0] k);
      logic [7:0] result;
      result = BYTE_COLON;
      if (int'(k) < MARK_LEN) begin
         result = MARK_TEXT[(MARK_LEN - 1 - int'(k)) * 8 +: 8];
      end
      return result;
   endfunction

   function automatic name_state_type name_step(input logic [NAME_COUNT-1:0] mask,
                                                input logic [3:0] len,
                                                input logic [7:0] c);
      name_state_type result;
      logic [7:0]     low;
      int             i;
      low = (c >= BYTE_UP_A && c <= BYTE_UP_Z) ? c + CASE_GAP : c;
      result.mask = mask;
      for (i = 0; i < NAME_COUNT; i++) begin
         if (len >= SECRET_LENS[i] || secret_char(i, len) != low) begin
            result.mask[i] = 1'b0;
         end
      end
      result.len = (len == LEN_MAX) ? len : len + 4'd1;
      return result;
   endfunction

endpackage

FILE: rtl/hhr_if.sv
// Valid/ready channel interfaces for raw request bytes and scrubbed result bytes.
interface hhr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_final;

   modport source (output valid, output data_byte, output is_final, input ready);
   modport sink (input valid, input data_byte, input is_final, output ready);
endinterface

interface hhr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_final;

   modport source (output valid, output out_byte, output out_final, input ready);
   modport sink (input valid, input out_byte, input out_final, output ready);
endinterface

FILE: rtl/hhr_front.sv
// Front end: tracks the request section and header name match, and issues emit commands.
module hhr_front
   import hhr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   hhr_req_if.sink    req,
   input  logic       queue_full,
   output logic       push,
   output cmd_type    push_cmd
);

   mode_type              mode_ff, mode_in;
   logic                  held_ff, held_in;
   logic [3:0]            len_ff, len_in;
   logic [NAME_COUNT-1:0] mask_ff, mask_in;

   logic                  take;
   logic [7:0]            c;
   logic                  fin;
   logic                  is_lf, is_cr, is_colon;
   logic                  line_mode;
   logic                  lead_cr;
   name_state_type        after_cr;
   name_state_type        after_c;
   logic                  hit;
   cmd_type               cmd;

   assign req.ready = !queue_full;
   assign take      = req.valid && req.ready;
   assign c         = req.data_byte;
   assign fin       = req.is_final;
   assign is_lf     = (c == BYTE_LF);
   assign is_cr     = (c == BYTE_CR);
   assign is_colon  = (c == BYTE_COLON);
   assign line_mode = (mode_ff == MODE_REQ) || (mode_ff == MODE_NAME) || (mode_ff == MODE_VALUE);
   assign lead_cr   = line_mode && held_ff && !is_lf;

   always_comb begin
      after_cr.mask = mask_ff;
      after_cr.len  = len_ff;
      if (lead_cr && mode_ff == MODE_NAME) begin
         after_cr = name_step(mask_ff, len_ff, BYTE_CR);
      end
   end

   assign after_c = name_step(after_cr.mask, after_cr.len, c);

   always_comb begin
      int i;
      hit = 1'b0;
      for (i = 0; i < NAME_COUNT; i++) begin
         if (after_cr.mask[i] && after_cr.len == SECRET_LENS[i]) begin
            hit = 1'b1;
         end
      end
   end

   always_comb begin
      mode_in = mode_ff;
      held_in = held_ff;
      len_in  = len_ff;
      mask_in = mask_ff;
      if (take) begin
         unique case (mode_ff)
            MODE_BODY: begin
               mode_in = MODE_BODY;
            end
            MODE_DROP: begin
               if (is_lf) begin
                  mode_in = MODE_NAME;
                  len_in  = '0;
                  mask_in = MASK_ALL;
               end
            end
            MODE_REQ, MODE_NAME, MODE_VALUE: begin
               held_in = 1'b0;
               len_in  = after_cr.len;
               mask_in = after_cr.mask;
               priority if (is_lf) begin
                  mode_in = (mode_ff == MODE_NAME && after_cr.len == '0) ? MODE_BODY : MODE_NAME;
                  len_in  = '0;
                  mask_in = MASK_ALL;
               end else if (is_cr) begin
                  held_in = 1'b1;
               end else if (mode_ff == MODE_NAME && is_colon) begin
                  mode_in = hit ? MODE_DROP : MODE_VALUE;
               end else if (mode_ff == MODE_NAME) begin
                  len_in  = after_c.len;
                  mask_in = after_c.mask;
               end else begin
                  mode_in = mode_ff;
               end
            end
            default: begin
               mode_in = MODE_REQ;
            end
         endcase
         if (fin) begin
            mode_in = MODE_REQ;
            held_in = 1'b0;
            len_in  = '0;
            mask_in = MASK_ALL;
         end
      end
   end

   always_comb begin
      cmd.lead_cr    = lead_cr;
      cmd.main_kind  = MAIN_BYTE;
      cmd.main_byte  = c;
      cmd.tail_lf    = fin && !is_lf;
      cmd.final_beat = fin;
      unique case (mode_ff)
         MODE_BODY: begin
            cmd.main_kind = MAIN_BYTE;
         end
         MODE_DROP: begin
            cmd.main_kind = is_lf ? MAIN_BYTE : MAIN_NONE;
         end
         MODE_REQ, MODE_NAME, MODE_VALUE: begin
            priority if (is_lf) begin
               cmd.main_kind = MAIN_BYTE;
            end else if (is_cr) begin
               cmd.main_kind = MAIN_NONE;
            end else if (mode_ff == MODE_NAME && is_colon) begin
               cmd.main_kind = hit ? MAIN_MARK : MAIN_BYTE;
            end else begin
               cmd.main_kind = MAIN_BYTE;
            end
         end
         default: begin
            cmd.main_kind = MAIN_NONE;
         end
      endcase
   end

   assign push     = take && (cmd.lead_cr || cmd.main_kind != MAIN_NONE || cmd.tail_lf);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_REQ;
         held_ff <= 1'b0;
         len_ff  <= '0;
         mask_ff <= MASK_ALL;
      end else begin
         mode_ff <= mode_in;
         held_ff <= held_in;
         len_ff  <= len_in;
         mask_ff <= mask_in;
      end
   end

endmodule

FILE: rtl/hhr_queue.sv
// Short command queue between the front end and the byte expander.
module hhr_queue
   import hhr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + COUNT_W'(do_push) - COUNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/hhr_back.sv
// Back end: expands each command into result beats through a registered output stage.
module hhr_back
   import hhr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head_cmd,
   output logic       pop,
   hhr_rsp_if.source  rsp
);

   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       final_ff, final_in;

   logic       load;
   logic [3:0] total;
   logic [3:0] k;
   logic       last;

   assign load  = head_valid && (!rsp_valid_ff || rsp.ready);
   assign total = 4'(head_cmd.lead_cr) + 4'(head_cmd.tail_lf)
                + ((head_cmd.main_kind == MAIN_BYTE) ? 4'd1 :
                   (head_cmd.main_kind == MAIN_MARK) ? 4'(MARK_LEN) : 4'd0);
   assign k     = step_ff - 4'(head_cmd.lead_cr);
   assign last  = (step_ff == total - 4'd1);
   assign pop   = load && last;

   always_comb begin
      byte_in = BYTE_LF;
      priority if (head_cmd.lead_cr && step_ff == '0) begin
         byte_in = BYTE_CR;
      end else if (head_cmd.main_kind == MAIN_BYTE && k == '0) begin
         byte_in = head_cmd.main_byte;
      end else if (head_cmd.main_kind == MAIN_MARK && int'(k) < MARK_LEN) begin
         byte_in = mark_char(k);
      end else begin
         byte_in = BYTE_LF;
      end
      final_in = last && head_cmd.final_beat;
   end

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         step_in      = last ? '0 : step_ff + 4'd1;
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= byte_in;
         final_ff <= final_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_byte  = byte_ff;
   assign rsp.out_final = final_ff;

endmodule

FILE: rtl/http_header_redactor.sv
// Top level of the HTTP header redactor.
// The block takes one request byte per beat and returns the scrubbed request one byte per
// beat, with the final flag on the last result beat. Bytes that map to one result flow at
// one beat per cycle while the result channel is ready; a CR held before a non-LF
// byte, the appended LF, and above all the twelve-byte redaction marker add one output
// beat per extra byte. The first result beat of an input beat passes through the command
// queue and then the registered output stage before it can be taken. The front end keeps
// accepting while the two-entry command queue has room. The command being expanded stays
// in the queue until its last beat is loaded, so during a marker the front end runs one
// command ahead of the output and then stalls its input. Bytes that produce nothing (a
// held CR, a dropped value byte) push no command and cost no output beat, but are still
// accepted only while the queue is not full.
module http_header_redactor
   import hhr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   hhr_req_if.sink    req_chan,
   hhr_rsp_if.source  rsp_chan
);

   logic    queue_full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   hhr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   hhr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   hhr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule
